/* hw/rtl/direct_form_fir_filter_unit_assert.svh */
// Assertion macros shared by the FIR filter checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef DIRECT_FORM_FIR_FILTER_UNIT_ASSERT_SVH
`define DIRECT_FORM_FIR_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define DFIR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define DFIR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dfir_pkg.sv */
// Shared sizes, stream field layout, operation codes and FSM states
// for the direct-form FIR filter. No dependencies.
`default_nettype none

package dfir_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int TAP_BITS    = 6;
    localparam int ORDER_BITS  = 6;
    localparam int OUT_BITS    = 38;

    localparam int ADDR_BITS  = $clog2(MAX_TAPS);
    localparam int COUNT_BITS = $clog2(MAX_TAPS + 1);
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;

    // Input tdata layout, lowest bits first
    localparam int SMP_LSB  = 0;
    localparam int TAP_LSB  = SMP_LSB + SAMPLE_BITS;
    localparam int COEF_LSB = TAP_LSB + TAP_BITS;
    localparam int S_TDATA_BITS = ((COEF_LSB + COEF_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/direct_form_fir_filter_unit.sv */
// Direct-form FIR filter: circular sample memory, coefficient memory and one MAC.
// Depends on dfir_pkg.
// A sample request runs taps = min(order+1, 64) multiply-accumulates, then flushes and
// loads the result; before the window is full it goes straight to the result. One request
// at a time: a sample holds the shared MAC until its result is loaded; a load does not.
// Synchronous active-low reset clears order, fill count and coefficient valid bits.
`default_nettype none

module direct_form_fir_filter_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_in[15:0], tap_index[21:16], coefficient_value[37:22], zero pad
    input  logic [dfir_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // operation[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // filtered_value[37:0], zero pad
    output logic [dfir_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // window_full[0]
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dfir_pkg::ORDER_BITS-1:0]    cfg_data
);
    import dfir_pkg::*;

    state_t                         state_reg, state_next;
    logic [ORDER_BITS-1:0]          order_reg;
    logic [ORDER_BITS:0]            order_p1;
    logic [COUNT_BITS-1:0]          taps;
    logic [ADDR_BITS-1:0]           ptr_reg, ptr_next, ptr_inc;
    logic [COUNT_BITS-1:0]          fill_reg, fill_next, fill_inc;
    logic [COUNT_BITS-1:0]          cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]           cnt_addr;
    logic                           cnt_last;
    logic                           full_reg, full_next;
    logic                           s_req, samp_acc, load_ok;
    logic                           issue, out_load;
    logic signed [SAMPLE_BITS-1:0]  in_sample;
    logic signed [COEF_BITS-1:0]    in_coef;
    logic [TAP_BITS-1:0]            in_tap;
    logic [SAMPLE_BITS-1:0]         dly_mem [MAX_TAPS];
    logic [COEF_BITS-1:0]           coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]            coef_vld_reg;
    logic [ADDR_BITS-1:0]           dly_addr;
    logic signed [SAMPLE_BITS-1:0]  smp_reg;
    logic signed [COEF_BITS-1:0]    coef_reg, coef_eff;
    logic                           coef_ok_reg;
    logic                           p1_vld_reg, p2_vld_reg;
    logic signed [PROD_BITS-1:0]    prod_reg;
    logic signed [OUT_BITS-1:0]     acc_reg, acc_next;
    logic                           m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]            m_data_reg;
    logic                           m_full_reg;

    // Field unpacking
    assign in_sample = s_tdata[SMP_LSB +: SAMPLE_BITS];
    assign in_tap    = s_tdata[TAP_LSB +: TAP_BITS];
    assign in_coef   = s_tdata[COEF_LSB +: COEF_BITS];

    assign s_req    = s_tvalid && s_tready;
    assign samp_acc = s_req && (op_t'(s_tuser) == OP_FILTER);
    assign load_ok  = s_req && (op_t'(s_tuser) == OP_LOAD) && (int'(in_tap) < MAX_TAPS);

    // Tap count, clipped to the store depth
    assign order_p1 = {1'b0, order_reg} + 1'b1;
    assign taps     = (int'(order_p1) > MAX_TAPS) ? COUNT_BITS'(MAX_TAPS)
                                                   : COUNT_BITS'(order_p1);

    // Circular write pointer; newest sample sits at ptr_reg
    assign ptr_inc  = (ptr_reg == ADDR_BITS'(MAX_TAPS - 1)) ? '0 : ptr_reg + 1'b1;
    assign fill_inc = (int'(fill_reg) < MAX_TAPS) ? fill_reg + 1'b1 : fill_reg;
    assign cnt_addr = cnt_reg[ADDR_BITS-1:0];
    assign cnt_last = (cnt_reg == taps - 1'b1);
    assign dly_addr = (ptr_reg >= cnt_addr) ? ptr_reg - cnt_addr
                                            : ptr_reg + ADDR_BITS'(MAX_TAPS) - cnt_addr;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (samp_acc) begin
                    state_next = (fill_inc >= taps) ? ST_MAC : ST_RESULT;
                end
            end
            ST_MAC: begin
                if (cnt_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!p1_vld_reg && !p2_vld_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_MAC:    issue    = 1'b1;
            ST_FLUSH:  ;
            ST_RESULT: out_load = !m_valid_reg || m_tready;
            default:   ;
        endcase
    end

    // Control next values
    always_comb begin
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        full_next    = full_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        if (samp_acc) begin
            ptr_next  = ptr_inc;
            fill_next = fill_inc;
            full_next = (fill_inc >= taps);
            cnt_next  = '0;
            acc_next  = '0;
        end else begin
            if (issue) begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (p2_vld_reg) begin
                acc_next = acc_reg + OUT_BITS'(prod_reg);
            end
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            order_reg    <= '0;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            full_reg     <= 1'b0;
            cnt_reg      <= '0;
            coef_vld_reg <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            fill_reg    <= fill_next;
            full_reg    <= full_next;
            cnt_reg     <= cnt_next;
            p1_vld_reg  <= issue;
            p2_vld_reg  <= p1_vld_reg;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                order_reg <= cfg_data;
            end
            if (load_ok) begin
                coef_vld_reg[in_tap[ADDR_BITS-1:0]] <= 1'b1;
            end
        end
    end

    // Sample memory: write newest sample, read one tap per MAC cycle
    always_ff @(posedge aclk) begin
        if (samp_acc) begin
            dly_mem[ptr_inc] <= in_sample;
        end
        if (issue) begin
            smp_reg <= dly_mem[dly_addr];
        end
    end

    // Coefficient memory; unloaded slots read as zero through the valid bits
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            coef_mem[in_tap[ADDR_BITS-1:0]] <= in_coef;
        end
        if (issue) begin
            coef_reg    <= coef_mem[cnt_addr];
            coef_ok_reg <= coef_vld_reg[cnt_addr];
        end
    end

    // Multiply stage
    assign coef_eff = coef_ok_reg ? coef_reg : '0;

    always_ff @(posedge aclk) begin
        if (p1_vld_reg) begin
            prod_reg <= PROD_BITS'(smp_reg) * PROD_BITS'(coef_eff);
        end
    end

    // Accumulator and result register
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (out_load) begin
            m_data_reg <= full_reg ? acc_reg : '0;
            m_full_reg <= full_reg;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_BITS - OUT_BITS){1'b0}}, m_data_reg};
    assign m_tuser   = m_full_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/dfir_checker.sv */
// Port-level checker for the FIR filter, bound to every direct_form_fir_filter_unit instance.
// Depends on dfir_pkg and direct_form_fir_filter_unit_assert.svh.
`default_nettype none
`include "direct_form_fir_filter_unit_assert.svh"

module dfir_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [dfir_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input wire logic                               m_tuser
);
    import dfir_pkg::*;

    // Stalled result holds
    `DFIR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Result is zero until the window fills
    `DFIR_ASSERT_NOW(a_zero_early, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "nonzero result before window full")

    // Padding bits above the sum stay clear
    `DFIR_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_BITS-1:OUT_BITS] == '0, "tdata padding not zero")

    // An accepted filter request blocks the input
    `DFIR_ASSERT_NXT(a_one_sample, aclk, aresetn, s_tvalid && s_tready && (s_tuser == OP_FILTER), !s_tready, "input ready during filter run")

endmodule

bind direct_form_fir_filter_unit dfir_checker u_dfir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for direct_form_fir_filter_unit: sample and coefficient-load requests,
// a predictor of the tap sum and window flag, and order changes across idling phases.
// Depends on dfir_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_top;
    import dfir_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 80;   // longer than a full filter run at the largest order
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;

    typedef struct {
        logic [OUT_BITS-1:0] value;
        logic                full;
    } fir_output_t;

    // Tracks delay line, coefficients and order; holds the outputs still owed by the DUT
    class fir_output_board;
        logic signed [SAMPLE_BITS-1:0] sample_line [MAX_TAPS];
        logic signed [COEF_BITS-1:0]   coef_store [MAX_TAPS];
        int unsigned                   samples_seen;
        int unsigned                   order;
        fir_output_t                   owed_outputs [$];
        int                            errors;

        function new();
            for (int i = 0; i < MAX_TAPS; i++) begin
                sample_line[i] = '0;
                coef_store[i] = '0;
            end
            samples_seen = 0;
            order = 0;
            errors = 0;
        endfunction

        function void set_order(int unsigned new_order);
            order = new_order;
        endfunction

        // Accepted request: load a coefficient, or shift a sample and predict the output
        function void note_request(op_t op, logic [SAMPLE_BITS-1:0] smp,
                                   logic [TAP_BITS-1:0] tap, logic [COEF_BITS-1:0] coef);
            int unsigned taps;
            longint      acc;
            fir_output_t res;
            if (op == OP_LOAD) begin
                coef_store[tap] = coef;
                return;
            end
            for (int i = MAX_TAPS - 1; i > 0; i--)
                sample_line[i] = sample_line[i-1];
            sample_line[0] = smp;
            if (samples_seen < MAX_TAPS)
                samples_seen++;
            taps = (order + 1 > MAX_TAPS) ? MAX_TAPS : order + 1;
            acc = 0;
            res.full = (samples_seen >= taps);
            if (res.full) begin
                for (int n = 0; n < taps; n++)
                    acc += longint'(coef_store[n]) * longint'(sample_line[n]);
            end
            res.value = acc[OUT_BITS-1:0];
            owed_outputs.push_back(res);
        endfunction

        function void check_output(logic [OUT_BITS-1:0] value, logic full);
            fir_output_t want;
            if (owed_outputs.size() == 0) begin
                $display("%0t: unexpected output value %0d full %0b", $time,
                         $signed(value), full);
                errors++;
                return;
            end
            want = owed_outputs.pop_front();
            if (value !== want.value) begin
                $display("%0t: filtered_value expected %0d actual %0d", $time,
                         $signed(want.value), $signed(value));
                errors++;
            end
            if (full !== want.full) begin
                $display("%0t: window_full expected %0b actual %0b", $time,
                         want.full, full);
                errors++;
            end
        endfunction

        function int pending();
            return owed_outputs.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [ORDER_BITS-1:0]   cfg_data = '0;

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int unsigned cycle_count = 0;
    fir_output_board board = new();

    direct_form_fir_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Output backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Handshake monitor: values seen here are the ones before this edge's updates
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_request(op_t'(s_tuser), s_tdata[SMP_LSB +: SAMPLE_BITS],
                               s_tdata[TAP_LSB +: TAP_BITS], s_tdata[COEF_LSB +: COEF_BITS]);
        if (aresetn && m_tvalid && m_tready)
            board.check_output(m_tdata[OUT_BITS-1:0], m_tuser);
    end

    // One request, with random idle cycles ahead of it
    task automatic send_request(op_t op, logic [SAMPLE_BITS-1:0] smp,
                                logic [TAP_BITS-1:0] tap, logic [COEF_BITS-1:0] coef);
        logic [S_TDATA_BITS-1:0] word;
        word = '0;
        word[SMP_LSB +: SAMPLE_BITS] = smp;
        word[TAP_LSB +: TAP_BITS] = tap;
        word[COEF_LSB +: COEF_BITS] = coef;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Lower valid, wait for every owed output, then let any trailing work finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_order(logic [ORDER_BITS-1:0] new_order);
        cfg_valid <= 1'b1;
        cfg_data <= new_order;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        board.set_order(new_order);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Full-range value with extra weight on the extremes
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_request();
        if ($urandom_range(0, 99) < 20)
            send_request(OP_LOAD, 16'($urandom()), 6'($urandom()), pick_value());
        else
            send_request(OP_FILTER, pick_value(), 6'($urandom()), 16'($urandom()));
    endtask

    initial begin
        int unsigned phase_order;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: order 0 out of reset, full-scale values
        send_request(OP_LOAD, 16'h0000, 6'd0, 16'h7FFF);
        send_request(OP_FILTER, 16'h7FFF, 6'd0, 16'h0000);
        send_request(OP_FILTER, 16'h8000, 6'd63, 16'hFFFF);
        send_request(OP_FILTER, 16'h0000, 6'd0, 16'h0000);
        send_request(OP_LOAD, 16'hFFFF, 6'd1, 16'h8000);
        send_request(OP_FILTER, 16'hFFFF, 6'd0, 16'h0000);
        drain();

        // Largest order: window not full yet; top tap slot loaded
        write_order(6'd63);
        send_request(OP_LOAD, 16'h0000, 6'd63, 16'h8000);
        send_request(OP_LOAD, 16'h0000, 6'd62, 16'h7FFF);
        send_request(OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        send_request(OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        send_request(OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        drain();

        // Order lowered while samples are held: window full at once
        write_order(6'd2);
        send_request(OP_LOAD, 16'h0000, 6'd2, 16'h8000);
        send_request(OP_FILTER, 16'h8000, 6'd0, 16'h0000);
        send_request(OP_FILTER, 16'h7FFF, 6'd0, 16'h0000);
        send_request(OP_FILTER, 16'h0001, 6'd0, 16'h0000);
        drain();

        // Random phases, cycling through the idle and stall patterns
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0, 3:    phase_order = 63;
                1:       phase_order = 0;
                5:       phase_order = 1;
                default: phase_order = $urandom_range(2, 62);
            endcase
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            write_order(phase_order[ORDER_BITS-1:0]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_request();
            drain();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* direct_form_fir_filter_unit.f */
+incdir+hw/rtl
hw/rtl/dfir_pkg.sv
hw/rtl/direct_form_fir_filter_unit.sv
hw/rtl/dfir_checker.sv
sim/tb_top.sv
